### rtl/rti_pkg.sv
package rti_pkg;

	localparam int COORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int DIR_W = 18;
	localparam int NEAR_W = 16;
	localparam int DIST_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR = 3'd6;

	// edge / offset width: difference of two coordinates
	localparam int E_W = COORD_W + 1;
	// h = dir x e2
	localparam int H_W = DIR_W + E_W + 1;
	// q = s x e1
	localparam int Q_W = 2 * E_W + 1;
	// dot products
	localparam int A_W = E_W + H_W + 2;
	localparam int VN_W = DIR_W + Q_W + 2;
	localparam int TN_W = E_W + Q_W + 2;
	// common width for comparisons and the divider
	localparam int W_W = TN_W + FRAC_W + 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex0_x;
		logic signed [COORD_W-1:0] vertex0_y;
		logic signed [COORD_W-1:0] vertex0_z;
		logic signed [COORD_W-1:0] vertex1_x;
		logic signed [COORD_W-1:0] vertex1_y;
		logic signed [COORD_W-1:0] vertex1_z;
		logic signed [COORD_W-1:0] vertex2_x;
		logic signed [COORD_W-1:0] vertex2_y;
		logic signed [COORD_W-1:0] vertex2_z;
	} tri_in_t;

	typedef struct packed {
		logic hit;
		logic [DIST_W-1:0] hit_distance;
	} tri_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ox;
		logic signed [COORD_W-1:0] oy;
		logic signed [COORD_W-1:0] oz;
		logic signed [DIR_W-1:0] dx;
		logic signed [DIR_W-1:0] dy;
		logic signed [DIR_W-1:0] dz;
		logic [NEAR_W-1:0] eps;
	} ray_cfg_t;

	// front-end result handed across the queue
	typedef struct packed {
		logic rejected;
		logic [W_W-1:0] a;
		logic [W_W-1:0] num;
		logic [W_W-1:0] a31;
	} tri_job_t;

endpackage

### rtl/rti_front.sv
module rti_front (
	input logic clk,
	input logic arst_n,
	input rti_pkg::ray_cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input rti_pkg::tri_in_t in_data,
	output logic job_valid,
	input logic job_ready,
	output rti_pkg::tri_job_t job_data
);
	import rti_pkg::*;

	localparam int NST = 7;

	logic [NST-1:0] v_q;
	logic [NST-1:0] adv;

	logic signed [E_W-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [E_W-1:0] sx_s1, sy_s1, sz_s1;
	logic signed [DIR_W-1:0] dx_s1, dy_s1, dz_s1;

	logic signed [E_W+DIR_W-1:0] p_hx0_s2, p_hx1_s2, p_hy0_s2, p_hy1_s2, p_hz0_s2, p_hz1_s2;
	logic signed [2*E_W-1:0] p_qx0_s2, p_qx1_s2, p_qy0_s2, p_qy1_s2, p_qz0_s2, p_qz1_s2;
	logic signed [E_W-1:0] e1x_s2, e1y_s2, e1z_s2, e2x_s2, e2y_s2, e2z_s2;
	logic signed [E_W-1:0] sx_s2, sy_s2, sz_s2;
	logic signed [DIR_W-1:0] dx_s2, dy_s2, dz_s2;

	logic signed [H_W-1:0] hx_s3, hy_s3, hz_s3;
	logic signed [Q_W-1:0] qx_s3, qy_s3, qz_s3;
	logic signed [E_W-1:0] e1x_s3, e1y_s3, e1z_s3, e2x_s3, e2y_s3, e2z_s3;
	logic signed [E_W-1:0] sx_s3, sy_s3, sz_s3;
	logic signed [DIR_W-1:0] dx_s3, dy_s3, dz_s3;

	// products split into low/high halves of the wide operand
	localparam int QL = Q_W / 2;
	localparam int QH = Q_W - QL;
	localparam int HL = H_W / 2;
	localparam int HH = H_W - HL;
	// split point of |a| for the eps * a product
	localparam int AL = 44;
	logic signed [E_W+HL:0] pal_s4 [3];
	logic signed [E_W+HH-1:0] pah_s4 [3];
	logic signed [E_W+HL:0] pul_s4 [3];
	logic signed [E_W+HH-1:0] puh_s4 [3];
	logic signed [DIR_W+QL:0] pvl_s4 [3];
	logic signed [DIR_W+QH-1:0] pvh_s4 [3];
	logic signed [E_W+QL:0] ptl_s4 [3];
	logic signed [E_W+QH-1:0] pth_s4 [3];

	logic signed [W_W-1:0] a_s5, un_s5, vn_s5, tn_s5;
	logic signed [W_W-1:0] a_s6, un_s6, vn_s6, num_s6;
	logic [NEAR_W-1:0] eps_s6;
	logic signed [W_W-1:0] a_s7, num_s7;
	logic [NEAR_W+AL-1:0] eal_s7;
	logic [NEAR_W+A_W-AL-1:0] eah_s7;
	logic rej_s7;
	logic rej_all;

	always_comb begin
		adv[NST-1] = !v_q[NST-1] || job_ready;
		for (int i = NST - 2; i >= 0; i--)
			adv[i] = !v_q[i] || adv[i+1];
	end

	assign in_ready = adv[0];
	assign job_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int i = 1; i < NST; i++)
				if (adv[i])
					v_q[i] <= v_q[i-1];
		end
	end

	logic signed [W_W-1:0] eps_big;
	assign eps_big = W_W'(eps_s6) <<< (2 * FRAC_W);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			e1x_s1 <= E_W'(in_data.vertex1_x) - E_W'(in_data.vertex0_x);
			e1y_s1 <= E_W'(in_data.vertex1_y) - E_W'(in_data.vertex0_y);
			e1z_s1 <= E_W'(in_data.vertex1_z) - E_W'(in_data.vertex0_z);
			e2x_s1 <= E_W'(in_data.vertex2_x) - E_W'(in_data.vertex0_x);
			e2y_s1 <= E_W'(in_data.vertex2_y) - E_W'(in_data.vertex0_y);
			e2z_s1 <= E_W'(in_data.vertex2_z) - E_W'(in_data.vertex0_z);
			sx_s1 <= E_W'(cfg.ox) - E_W'(in_data.vertex0_x);
			sy_s1 <= E_W'(cfg.oy) - E_W'(in_data.vertex0_y);
			sz_s1 <= E_W'(cfg.oz) - E_W'(in_data.vertex0_z);
			dx_s1 <= cfg.dx;
			dy_s1 <= cfg.dy;
			dz_s1 <= cfg.dz;
		end
		if (adv[1]) begin
			p_hx0_s2 <= dy_s1 * e2z_s1;
			p_hx1_s2 <= dz_s1 * e2y_s1;
			p_hy0_s2 <= dz_s1 * e2x_s1;
			p_hy1_s2 <= dx_s1 * e2z_s1;
			p_hz0_s2 <= dx_s1 * e2y_s1;
			p_hz1_s2 <= dy_s1 * e2x_s1;
			p_qx0_s2 <= sy_s1 * e1z_s1;
			p_qx1_s2 <= sz_s1 * e1y_s1;
			p_qy0_s2 <= sz_s1 * e1x_s1;
			p_qy1_s2 <= sx_s1 * e1z_s1;
			p_qz0_s2 <= sx_s1 * e1y_s1;
			p_qz1_s2 <= sy_s1 * e1x_s1;
			e1x_s2 <= e1x_s1; e1y_s2 <= e1y_s1; e1z_s2 <= e1z_s1;
			e2x_s2 <= e2x_s1; e2y_s2 <= e2y_s1; e2z_s2 <= e2z_s1;
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; sz_s2 <= sz_s1;
			dx_s2 <= dx_s1; dy_s2 <= dy_s1; dz_s2 <= dz_s1;
		end
		if (adv[2]) begin
			hx_s3 <= H_W'(p_hx0_s2) - H_W'(p_hx1_s2);
			hy_s3 <= H_W'(p_hy0_s2) - H_W'(p_hy1_s2);
			hz_s3 <= H_W'(p_hz0_s2) - H_W'(p_hz1_s2);
			qx_s3 <= Q_W'(p_qx0_s2) - Q_W'(p_qx1_s2);
			qy_s3 <= Q_W'(p_qy0_s2) - Q_W'(p_qy1_s2);
			qz_s3 <= Q_W'(p_qz0_s2) - Q_W'(p_qz1_s2);
			e1x_s3 <= e1x_s2; e1y_s3 <= e1y_s2; e1z_s3 <= e1z_s2;
			e2x_s3 <= e2x_s2; e2y_s3 <= e2y_s2; e2z_s3 <= e2z_s2;
			sx_s3 <= sx_s2; sy_s3 <= sy_s2; sz_s3 <= sz_s2;
			dx_s3 <= dx_s2; dy_s3 <= dy_s2; dz_s3 <= dz_s2;
		end
		if (adv[3]) begin
			pal_s4[0] <= e1x_s3 * $signed({1'b0, hx_s3[HL-1:0]});
			pal_s4[1] <= e1y_s3 * $signed({1'b0, hy_s3[HL-1:0]});
			pal_s4[2] <= e1z_s3 * $signed({1'b0, hz_s3[HL-1:0]});
			pah_s4[0] <= e1x_s3 * $signed(hx_s3[H_W-1:HL]);
			pah_s4[1] <= e1y_s3 * $signed(hy_s3[H_W-1:HL]);
			pah_s4[2] <= e1z_s3 * $signed(hz_s3[H_W-1:HL]);
			pul_s4[0] <= sx_s3 * $signed({1'b0, hx_s3[HL-1:0]});
			pul_s4[1] <= sy_s3 * $signed({1'b0, hy_s3[HL-1:0]});
			pul_s4[2] <= sz_s3 * $signed({1'b0, hz_s3[HL-1:0]});
			puh_s4[0] <= sx_s3 * $signed(hx_s3[H_W-1:HL]);
			puh_s4[1] <= sy_s3 * $signed(hy_s3[H_W-1:HL]);
			puh_s4[2] <= sz_s3 * $signed(hz_s3[H_W-1:HL]);
			pvl_s4[0] <= dx_s3 * $signed({1'b0, qx_s3[QL-1:0]});
			pvl_s4[1] <= dy_s3 * $signed({1'b0, qy_s3[QL-1:0]});
			pvl_s4[2] <= dz_s3 * $signed({1'b0, qz_s3[QL-1:0]});
			pvh_s4[0] <= dx_s3 * $signed(qx_s3[Q_W-1:QL]);
			pvh_s4[1] <= dy_s3 * $signed(qy_s3[Q_W-1:QL]);
			pvh_s4[2] <= dz_s3 * $signed(qz_s3[Q_W-1:QL]);
			ptl_s4[0] <= e2x_s3 * $signed({1'b0, qx_s3[QL-1:0]});
			ptl_s4[1] <= e2y_s3 * $signed({1'b0, qy_s3[QL-1:0]});
			ptl_s4[2] <= e2z_s3 * $signed({1'b0, qz_s3[QL-1:0]});
			pth_s4[0] <= e2x_s3 * $signed(qx_s3[Q_W-1:QL]);
			pth_s4[1] <= e2y_s3 * $signed(qy_s3[Q_W-1:QL]);
			pth_s4[2] <= e2z_s3 * $signed(qz_s3[Q_W-1:QL]);
		end
		if (adv[4]) begin
			a_s5 <= W_W'(pal_s4[0]) + W_W'(pal_s4[1]) + W_W'(pal_s4[2])
				+ ((W_W'(pah_s4[0]) + W_W'(pah_s4[1]) + W_W'(pah_s4[2])) <<< HL);
			un_s5 <= W_W'(pul_s4[0]) + W_W'(pul_s4[1]) + W_W'(pul_s4[2])
				+ ((W_W'(puh_s4[0]) + W_W'(puh_s4[1]) + W_W'(puh_s4[2])) <<< HL);
			vn_s5 <= W_W'(pvl_s4[0]) + W_W'(pvl_s4[1]) + W_W'(pvl_s4[2])
				+ ((W_W'(pvh_s4[0]) + W_W'(pvh_s4[1]) + W_W'(pvh_s4[2])) <<< QL);
			tn_s5 <= W_W'(ptl_s4[0]) + W_W'(ptl_s4[1]) + W_W'(ptl_s4[2])
				+ ((W_W'(pth_s4[0]) + W_W'(pth_s4[1]) + W_W'(pth_s4[2])) <<< QL);
		end
		if (adv[5]) begin
			if (a_s5 < 0) begin
				a_s6 <= -a_s5;
				un_s6 <= -un_s5;
				vn_s6 <= -vn_s5;
				num_s6 <= (-tn_s5) <<< FRAC_W;
			end else begin
				a_s6 <= a_s5;
				un_s6 <= un_s5;
				vn_s6 <= vn_s5;
				num_s6 <= tn_s5 <<< FRAC_W;
			end
			eps_s6 <= cfg.eps;
		end
		if (adv[6]) begin
			a_s7 <= a_s6;
			num_s7 <= num_s6;
			eal_s7 <= eps_s6 * a_s6[AL-1:0];
			eah_s7 <= eps_s6 * a_s6[A_W-1:AL];
			rej_s7 <= (a_s6 == '0) || (a_s6 < eps_big) || (un_s6 < 0) || (a_s6 < un_s6)
				|| (vn_s6 < 0) || (a_s6 < un_s6 + vn_s6);
		end
	end

	logic [W_W-1:0] eps_a;
	assign eps_a = W_W'(eal_s7) + (W_W'(eah_s7) << AL);
	assign rej_all = rej_s7 || !($signed(eps_a) < num_s7);

	assign job_data.rejected = rej_all;
	assign job_data.a = a_s7;
	assign job_data.num = num_s7;
	assign job_data.a31 = a_s7 << 31;

endmodule

### rtl/rti_queue.sv
module rti_queue #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input rti_pkg::tri_job_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output rti_pkg::tri_job_t rd_data
);
	import rti_pkg::*;

	localparam int PW = $clog2(DEPTH);

	tri_job_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (PW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule

### rtl/rti_back.sv
module rti_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input rti_pkg::tri_job_t job_data,
	output logic out_valid,
	input logic out_ready,
	output rti_pkg::tri_out_t out_data
);
	import rti_pkg::*;

	// one quotient bit per stage, restoring division
	localparam int NST = DIST_W + 1;

	logic [NST-1:0] v_q;
	logic [NST-1:0] adv;
	logic [W_W-1:0] a_q [NST];
	logic [W_W-1:0] rem_q [NST];
	logic [DIST_W-1:0] quo_q [NST];
	logic rej_q [NST];
	logic sat_q [NST];

	always_comb begin
		adv[NST-1] = !v_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--)
			adv[i] = !v_q[i] || adv[i+1];
	end

	assign job_ready = adv[0];
	assign out_valid = v_q[NST-1];
	assign out_data.hit = !rej_q[NST-1];
	assign out_data.hit_distance = rej_q[NST-1] ? '0 :
		(sat_q[NST-1] ? {DIST_W{1'b1}} : quo_q[NST-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= job_valid;
			for (int i = 1; i < NST; i++)
				if (adv[i])
					v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			a_q[0] <= job_data.a;
			rem_q[0] <= job_data.num;
			quo_q[0] <= '0;
			rej_q[0] <= job_data.rejected;
			sat_q[0] <= !($signed(job_data.num) < $signed(job_data.a31));
		end
		for (int i = 1; i < NST; i++) begin
			if (adv[i]) begin
				a_q[i] <= a_q[i-1];
				rej_q[i] <= rej_q[i-1];
				sat_q[i] <= sat_q[i-1];
				if (rem_q[i-1] >= (a_q[i-1] << (DIST_W - i))) begin
					rem_q[i] <= rem_q[i-1] - (a_q[i-1] << (DIST_W - i));
					quo_q[i] <= quo_q[i-1] | (DIST_W'(1) << (DIST_W - i));
				end else begin
					rem_q[i] <= rem_q[i-1];
					quo_q[i] <= quo_q[i-1];
				end
			end
		end
	end

	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	ap_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> out_data.hit_distance == '0)
		else $error("miss with nonzero distance");
	ap_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[0] && !adv[1]) |-> !job_ready)
		else $error("back end accepted into a full stage");

endmodule

### rtl/ray_triangle_intersect_unit.sv
// channel | handshake               | payload
// config  | cfg_we                  | cfg_index, cfg_data
// input   | in_valid / in_ready     | in_data (three vertices)
// output  | out_valid / out_ready   | out_data (hit, hit_distance)
// One triangle per cycle sustained while out_ready stays high; 7 front stages, the queue, then 32 divider stages.
// The rate is set by the fully pipelined multiplier stages and one-bit-per-stage divider.
// arst_n clears valid flags and the ray registers to their reset values.
// A stalled output holds every occupied stage while empty stages still fill; the queue holds up to QUEUE_DEPTH items.
module ray_triangle_intersect_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rti_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input rti_pkg::tri_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rti_pkg::tri_out_t out_data
);
	import rti_pkg::*;

	ray_cfg_t cfg_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	tri_job_t fj_data, bj_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ox <= '0;
			cfg_q.oy <= '0;
			cfg_q.oz <= '0;
			cfg_q.dx <= '0;
			cfg_q.dy <= '0;
			cfg_q.dz <= DIR_W'(1 << FRAC_W);
			cfg_q.eps <= NEAR_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: cfg_q.ox <= cfg_data;
				REG_ORIGIN_Y: cfg_q.oy <= cfg_data;
				REG_ORIGIN_Z: cfg_q.oz <= cfg_data;
				REG_DIR_X: cfg_q.dx <= cfg_data[DIR_W-1:0];
				REG_DIR_Y: cfg_q.dy <= cfg_data[DIR_W-1:0];
				REG_DIR_Z: cfg_q.dz <= cfg_data[DIR_W-1:0];
				REG_NEAR: cfg_q.eps <= cfg_data[NEAR_W-1:0];
				default: ;
			endcase
		end
	end

	rti_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
	);

	rti_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj_data),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj_data)
	);

	rti_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

### dv/tb_top.sv
module tb_top;
	import rti_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	tri_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tri_out_t out_data;

	ray_triangle_intersect_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// ray registers as the predictor sees them
	logic signed [COORD_W-1:0] org_x, org_y, org_z;
	logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
	logic [NEAR_W-1:0] near_eps;

	tri_out_t pending_hits[$];
	int error_count = 0;
	int result_count = 0;
	int hit_count = 0;
	int hold_off = 0;
	bit rx_busy_mode = 1'b1;

	function automatic tri_out_t predict_hit(tri_in_t t);
		logic signed [255:0] v0x, v0y, v0z, e1x, e1y, e1z, e2x, e2y, e2z;
		logic signed [255:0] dx, dy, dz, hx, hy, hz, sx, sy, sz, qx, qy, qz;
		logic signed [255:0] a, un, vn, tn, num, eps, q;
		tri_out_t r;
		r = '0;
		v0x = t.vertex0_x; v0y = t.vertex0_y; v0z = t.vertex0_z;
		e1x = 256'(signed'(t.vertex1_x)) - v0x;
		e1y = 256'(signed'(t.vertex1_y)) - v0y;
		e1z = 256'(signed'(t.vertex1_z)) - v0z;
		e2x = 256'(signed'(t.vertex2_x)) - v0x;
		e2y = 256'(signed'(t.vertex2_y)) - v0y;
		e2z = 256'(signed'(t.vertex2_z)) - v0z;
		dx = dir_x; dy = dir_y; dz = dir_z;
		eps = {240'd0, near_eps};
		hx = dy * e2z - dz * e2y;
		hy = dz * e2x - dx * e2z;
		hz = dx * e2y - dy * e2x;
		a = e1x * hx + e1y * hy + e1z * hz;
		sx = 256'(signed'(org_x)) - v0x;
		sy = 256'(signed'(org_y)) - v0y;
		sz = 256'(signed'(org_z)) - v0z;
		un = sx * hx + sy * hy + sz * hz;
		qx = sy * e1z - sz * e1y;
		qy = sz * e1x - sx * e1z;
		qz = sx * e1y - sy * e1x;
		vn = dx * qx + dy * qy + dz * qz;
		tn = e2x * qx + e2y * qy + e2z * qz;
		if (a < 0) begin
			a = -a; un = -un; vn = -vn; tn = -tn;
		end
		if (a == 0) return r;
		if (a < (eps <<< (2 * FRAC_W))) return r;
		if (un < 0 || un > a) return r;
		if (vn < 0 || un + vn > a) return r;
		num = tn <<< FRAC_W;
		if (eps * a >= num) return r;
		r.hit = 1'b1;
		q = num / a;
		r.hit_distance = (q >= 256'sh7FFFFFFF) ? 31'h7FFFFFFF : q[30:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		unique case (idx)
			REG_ORIGIN_X: org_x = val;
			REG_ORIGIN_Y: org_y = val;
			REG_ORIGIN_Z: org_z = val;
			REG_DIR_X: dir_x = val[DIR_W-1:0];
			REG_DIR_Y: dir_y = val[DIR_W-1:0];
			REG_DIR_Z: dir_z = val[DIR_W-1:0];
			REG_NEAR: near_eps = val[NEAR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, int ne);
		wait_drained();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_NEAR, ne);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_triangle(tri_in_t t, bit gaps);
		int n;
		n = gaps ? idle_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_hits.insert(pending_hits.size(), predict_hit(t));
	endtask

	function automatic tri_in_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
		int x2, int y2, int z2);
		tri_in_t t;
		t = {x0, y0, z0, x1, y1, z1, x2, y2, z2};
		return t;
	endfunction

	// triangle around the ray axis at depth z, spread scale s, jittered
	function automatic tri_in_t facing_tri(int s, int z);
		tri_in_t t;
		t.vertex0_x = -s + $urandom_range(0, s / 2);
		t.vertex0_y = -s + $urandom_range(0, s / 2);
		t.vertex0_z = z + $urandom_range(0, 4096) - 2048;
		t.vertex1_x = s - $urandom_range(0, s / 2);
		t.vertex1_y = -s + $urandom_range(0, s / 2);
		t.vertex1_z = z + $urandom_range(0, 4096) - 2048;
		t.vertex2_x = $urandom_range(0, s) - s / 2;
		t.vertex2_y = s - $urandom_range(0, s / 2);
		t.vertex2_z = z + $urandom_range(0, 4096) - 2048;
		return t;
	endfunction

	function automatic tri_in_t random_tri();
		tri_in_t t;
		for (int i = 0; i < 9; i++) t[i*32 +: 32] = $urandom();
		return t;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			result_count++;
			if (pending_hits.size() == 0) begin
				report_mismatch("unexpected result", out_data, 32'd0);
			end else begin
				tri_out_t want;
				want = pending_hits.pop_front();
				if (want.hit) hit_count++;
				if (out_data.hit !== want.hit)
					report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
				if (out_data.hit_distance !== want.hit_distance)
					report_mismatch("hit_distance", 32'(out_data.hit_distance),
						32'(want.hit_distance));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (rx_busy_mode) begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic test_directed();
		int m;
		m = 32'h8000_0000;
		send_triangle(make_tri(-65536, -65536, 655360, 65536, -65536, 655360,
			0, 65536, 655360), 0);
		send_triangle(make_tri(0, 0, 131072, 65536, 0, 131072, 0, 65536, 131072), 0);
		send_triangle(make_tri(65536, 65536, 65536, 131072, 65536, 65536,
			65536, 131072, 65536), 0);
		send_triangle(make_tri(0, 0, 0, 65536, 0, 65536, 0, 65536, 65536), 0);
		send_triangle(make_tri(0, 0, -65536, 65536, 0, -65536, 0, 65536, -65536), 0);
		send_triangle(make_tri(0, 0, 1, 65536, 0, 1, 0, 65536, 1), 0);
		send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0), 0);
		send_triangle(make_tri(0, 0, 0, 0, 0, 65536, 0, 65536, 0), 0);
		send_triangle(make_tri(0, 0, 65536, 0, 0, 65536, 0, 0, 65536), 0);
		send_triangle(make_tri(0, 0, 65536, 1, 0, 65536, 0, 1, 65536), 0);
		send_triangle(make_tri(-m, -m, 32'h7fffffff, 32'h7fffffff, -m, 32'h7fffffff,
			-m, 32'h7fffffff, 32'h7fffffff), 0);
		send_triangle(make_tri(32'h7fffffff, 32'h7fffffff, -m, -m, 32'h7fffffff, -m,
			32'h7fffffff, -m, 32'h7fffffff), 0);
		send_triangle(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1), 0);
		send_triangle(make_tri(m, m, m, m, m, m, m, m, m), 0);
		set_ray(0, 0, 0, 65536, 0, 0, 0);
		send_triangle(make_tri(65536, -65536, -65536, 65536, 65536, -65536,
			65536, 0, 65536), 0);
		send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
		set_ray(0, 0, 0, -65536, 131071, -131072, 65535);
		send_triangle(make_tri(-65536, 0, 0, 0, 65536, 0, 0, 0, -65536), 0);
		send_triangle(make_tri(-655360, 0, 0, 0, 655360, 0, 0, 0, -655360), 0);
		set_ray(32'h7fffffff, -m, 0, 0, 0, 65536, 1);
		send_triangle(facing_tri(1 << 20, 1 << 30), 0);
	endtask

	task automatic test_random(int count, bit gaps);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7)
				send_triangle(facing_tri(1 << $urandom_range(10, 24),
					$urandom() >>> $urandom_range(0, 31)), gaps);
			else
				send_triangle(random_tri(), gaps);
		end
	endtask

	task automatic test_random_rays();
		for (int r = 0; r < 8; r++) begin
			set_ray($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
				(r % 2) ? -($urandom_range(0, 1 << 20)) : $urandom_range(0, 1 << 20),
				$urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
				(r % 2) ? -65536 : 65536 - $urandom_range(0, 2000),
				(r == 3) ? 0 : $urandom_range(0, 300));
			test_random(110, 1);
		end
		set_ray(0, 0, 0, $urandom(), $urandom(), $urandom(), $urandom());
		test_random(100, 1);
	endtask

	task automatic test_backpressure();
		set_ray(0, 0, 0, 0, 0, 65536, 16);
		hold_off = 300;
		test_random(60, 0);
		wait_drained();
		rx_busy_mode = 1'b0;
		test_random(80, 0);
		rx_busy_mode = 1'b1;
	endtask

	initial begin
		org_x = 0; org_y = 0; org_z = 0;
		dir_x = 0; dir_y = 0; dir_z = 18'sd65536;
		near_eps = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_rays();
		test_backpressure();
		wait_drained();
		$display("Checked %0d results (%0d hits) over directed triangles, random rays",
			result_count, hit_count);
		$display("and triangles, saturating and degenerate cases, and output backpressure.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout waiting for results");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
